FILE: design/lsn_pkg.sv
`default_nettype none

package lsn_pkg;

  // Input and result layouts of the normalizer channels.
  typedef struct packed {
    logic [15:0] level;
    logic        is_last;
  } lsn_in_t;

  typedef struct packed {
    logic [15:0] from_lightest;
    logic [15:0] from_darkest;
    logic [15:0] range_width;
    logic [14:0] percent_q8;
    logic        flat_batch;
    logic        overflowed;
    logic        final_result;
  } lsn_out_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_SPAN,
    ST_SCALE,
    ST_DIV,
    ST_OUT
  } lsn_state_e;

  // 100 percent in Q.8.
  localparam logic [14:0] PCT_SCALE = 15'd25600;

  // The quotient never exceeds PCT_SCALE, so only its low 15 bits are developed.
  localparam int unsigned QUO_W     = 15;
  localparam int unsigned DIV_CNT_W = 4;

endpackage

`default_nettype wire

FILE: design/lightness_span_normalizer_unit.sv
// Lightness span normalizer.
// The input channel (in_valid_i / in_ready_o / in_item_i) takes one lightness
// value per item. The final value of a batch carries is_last. Up to MAX_ITEMS
// values are stored in an internal memory while the darkest and lightest values
// are tracked. Values that arrive after the store is full are dropped, and the
// overflowed flag is raised on every result of that batch.
// During loading, in_ready_o is high and a value is taken whenever in_valid_i is high.
// After the is_last item is accepted, the block stops taking items and emits
// one result item per stored value on the output channel
// (out_valid_o / out_ready_i / out_item_o), in arrival order.
// Each result passes through one memory read, one subtract stage, one
// multiply by 25600, and 15 steps of the shared restoring divider, and
// then sits in the output register.
// While the receiver stalls, the result holds in the output register and
// the divider waits. After the final result is taken, the batch state
// clears and in_ready_o rises again.
// Reset puts the block in the loading state with an empty batch.
// The memory contents are not cleared.
`default_nettype none

module lightness_span_normalizer_unit
  import lsn_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lsn_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output lsn_out_t      out_item_o
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ITEMS);
  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(QUO_W - 1);

  lsn_state_e state_q, state_d;

  // Batch state.
  logic [15:0]     mem_q [MAX_ITEMS];
  logic [CntW-1:0] count_q;
  logic [15:0]     min_q;
  logic [15:0]     max_q;
  logic            drop_q;

  // Output sequencing and divider.
  logic [IdxW-1:0]      rd_idx_q;
  logic [15:0]          rd_data_q;
  logic [15:0]          above_q;
  logic [15:0]          span_q;
  logic [15:0]          rem_q;
  logic [QUO_W-1:0]     low_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] step_q;
  lsn_out_t             out_q;

  logic            in_fire;
  logic            out_fire;
  logic            has_room;
  logic            is_final;
  logic [30:0]     product;
  logic [17:0]     trial;
  logic            borrow;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign has_room = (count_q < CntMax);
  assign is_final = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);

  // Scaled offset; it stays below 2^31 for any 16-bit offset.
  assign product = 31'(above_q) * 31'(PCT_SCALE);

  // One restoring division step: shift in the next dividend bit and try
  // to subtract the span.
  assign trial  = {1'b0, rem_q, low_q[QUO_W-1]} - {2'b00, span_q};
  assign borrow = trial[17];

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && in_item_i.is_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ:  state_d = ST_SPAN;
      ST_SPAN:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == DivLast) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          state_d = is_final ? ST_LOAD : ST_READ;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: in_ready_o  = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // The value store is written during loading and read one entry at a time.
  always_ff @(posedge clk_i) begin
    if (in_fire && has_room) begin
      mem_q[count_q[IdxW-1:0]] <= in_item_i.level;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_idx_q];
  end

  // Batch bookkeeping. The first stored value seeds both extremes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      min_q    <= '0;
      max_q    <= '0;
      drop_q   <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      if (in_fire) begin
        if (has_room) begin
          count_q <= count_q + CntW'(1);
          if (count_q == '0) begin
            min_q <= in_item_i.level;
            max_q <= in_item_i.level;
          end else begin
            if (in_item_i.level > max_q) begin
              max_q <= in_item_i.level;
            end
            if (in_item_i.level < min_q) begin
              min_q <= in_item_i.level;
            end
          end
        end else begin
          drop_q <= 1'b1;
        end
        rd_idx_q <= '0;
      end
      if ((state_q == ST_OUT) && out_fire) begin
        if (is_final) begin
          count_q  <= '0;
          min_q    <= '0;
          max_q    <= '0;
          drop_q   <= 1'b0;
          rd_idx_q <= '0;
        end else begin
          rd_idx_q <= rd_idx_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (state_q == ST_DIV) begin
      step_q <= step_q + DIV_CNT_W'(1);
    end else begin
      step_q <= '0;
    end
  end

  // Datapath of one result.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_SPAN: begin
        above_q                  <= rd_data_q - min_q;
        span_q                   <= max_q - min_q;
        out_q.from_lightest      <= max_q - rd_data_q;
        out_q.from_darkest       <= rd_data_q - min_q;
        out_q.range_width        <= max_q - min_q;
        out_q.flat_batch         <= (max_q == min_q);
        out_q.overflowed         <= drop_q;
        out_q.final_result       <= is_final;
      end
      ST_SCALE: begin
        // The top 16 bits of the scaled offset are already below the span,
        // so the division starts there and develops 15 quotient bits.
        rem_q <= product[30:QUO_W];
        low_q <= product[QUO_W-1:0];
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= borrow ? {rem_q[14:0], low_q[QUO_W-1]} : trial[15:0];
        low_q <= {low_q[QUO_W-2:0], 1'b0};
        quo_q <= {quo_q[QUO_W-2:0], ~borrow};
        if (step_q == DivLast) begin
          // A flat batch gives zero in place of the meaningless quotient.
          out_q.percent_q8 <= out_q.flat_batch ? '0 : {quo_q[QUO_W-2:0], ~borrow};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lsn_pkg::*;

  localparam int unsigned CAP          = 64;
  localparam int unsigned RANDOM_ITEMS = 370;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam lsn_out_t    NO_PIN       = '0;

  // Receiver behavior; it changes every so often.
  typedef enum int unsigned {
    RX_FREE,
    RX_COIN,
    RX_BURSTY,
    RX_SPARSE
  } rx_mode_e;

  // How the lightness values of one random batch are drawn.
  typedef enum int unsigned {
    LV_ANY,
    LV_CLUSTER,
    LV_FLAT,
    LV_EDGE,
    LV_FEW
  } lvl_style_e;

  // One row of the directed table. A row repeats its level reps times, and
  // is_last applies to the final repetition only. When pinned is set, the
  // final result of the batch closed by this row is the typed-in value.
  typedef struct packed {
    logic [15:0] level;
    logic        is_last;
    logic [6:0]  reps;
    logic        pinned;
    lsn_out_t    want;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  lsn_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_ready_i;
  lsn_out_t out_item_o;

  lightness_span_normalizer_unit #(
    .MAX_ITEMS(CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Own copy of the batch state, kept in step with accepted items.
  logic [15:0] level_store [CAP];
  int unsigned level_count   = 0;
  logic [15:0] batch_lo      = '0;
  logic [15:0] batch_hi      = '0;
  logic        batch_dropped = 1'b0;

  lsn_out_t    normalized_q [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned stall_request  = 0;
  int unsigned burst_left     = 0;

  stim_row_t directed_rows [19] = '{
    '{16'h0000, 1'b1, 7'd1,  1'b1, '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b0, 1'b1}},
    '{16'hFFFF, 1'b1, 7'd1,  1'b1, '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b0, 1'b1}},
    '{16'h0000, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'hFFFF, 1'b1, 7'd1,  1'b1,
      '{16'd0, 16'd65535, 16'd65535, 15'd25600, 1'b0, 1'b0, 1'b1}},
    '{16'hFFFF, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'h0000, 1'b1, 7'd1,  1'b1,
      '{16'd65535, 16'd0, 16'd65535, 15'd0, 1'b0, 1'b0, 1'b1}},
    '{16'd1000, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'd3000, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'd2000, 1'b1, 7'd1,  1'b1,
      '{16'd1000, 16'd1000, 16'd2000, 15'd12800, 1'b0, 1'b0, 1'b1}},
    '{16'd7,    1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'd8,    1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'd8,    1'b1, 7'd1,  1'b0, NO_PIN},
    '{16'hAAAA, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'h5555, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'h0001, 1'b1, 7'd1,  1'b0, NO_PIN},
    '{16'd1234, 1'b0, 7'd1,  1'b0, NO_PIN},
    '{16'd1234, 1'b1, 7'd1,  1'b1, '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b0, 1'b1}},
    // A full store; the zero that follows is dropped but still closes the batch.
    '{16'h8000, 1'b0, 7'd64, 1'b0, NO_PIN},
    '{16'h0000, 1'b1, 7'd1,  1'b1, '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1, 1'b1, 1'b1}}
  };

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic compare_result(lsn_out_t got, lsn_out_t want);
    if (got.from_lightest !== want.from_lightest) begin
      flag_mismatch($sformatf("from_lightest %0d, want %0d", got.from_lightest,
                              want.from_lightest));
    end
    if (got.from_darkest !== want.from_darkest) begin
      flag_mismatch($sformatf("from_darkest %0d, want %0d", got.from_darkest,
                              want.from_darkest));
    end
    if (got.range_width !== want.range_width) begin
      flag_mismatch($sformatf("range_width %0d, want %0d", got.range_width,
                              want.range_width));
    end
    if (got.percent_q8 !== want.percent_q8) begin
      flag_mismatch($sformatf("percent_q8 %0d, want %0d", got.percent_q8,
                              want.percent_q8));
    end
    if (got.flat_batch !== want.flat_batch) begin
      flag_mismatch($sformatf("flat_batch %b, want %b", got.flat_batch, want.flat_batch));
    end
    if (got.overflowed !== want.overflowed) begin
      flag_mismatch($sformatf("overflowed %b, want %b", got.overflowed, want.overflowed));
    end
    if (got.final_result !== want.final_result) begin
      flag_mismatch($sformatf("final_result %b, want %b", got.final_result,
                              want.final_result));
    end
  endtask

  // Folds one accepted item into the batch. On the closing item the
  // normalized result of every stored value is queued, in arrival order.
  task automatic absorb_level(lsn_in_t item, logic pinned, lsn_out_t pinned_want);
    logic [31:0] span;
    logic [31:0] above;
    logic [31:0] pct;
    lsn_out_t    res;
    if (level_count < CAP) begin
      level_store[level_count] = item.level;
      if (level_count == 0) begin
        batch_lo = item.level;
        batch_hi = item.level;
      end else begin
        if (item.level > batch_hi) batch_hi = item.level;
        if (item.level < batch_lo) batch_lo = item.level;
      end
      level_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (item.is_last) begin
      span = {16'd0, batch_hi} - {16'd0, batch_lo};
      for (int k = 0; k < level_count; k++) begin
        above = {16'd0, level_store[k]} - {16'd0, batch_lo};
        pct   = (span != 0) ? (above * {17'd0, PCT_SCALE}) / span : 32'd0;
        res.from_lightest = batch_hi - level_store[k];
        res.from_darkest  = above[15:0];
        res.range_width   = span[15:0];
        res.percent_q8    = pct[14:0];
        res.flat_batch    = (span == 0);
        res.overflowed    = batch_dropped;
        res.final_result  = (k + 1 == level_count);
        if (pinned && res.final_result) res = pinned_want;
        normalized_q.push_back(res);
      end
      level_count   = 0;
      batch_lo      = '0;
      batch_hi      = '0;
      batch_dropped = 1'b0;
    end
  endtask

  // Called just after a rising edge. Holds the item until it is taken, then
  // either keeps valid high for the next item or opens a gap between bursts.
  task automatic send_item(lsn_in_t item, logic pinned, lsn_out_t pinned_want);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_level(item, pinned, pinned_want);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Activity tracking for the watchdog and result checking, sampled at the rising edge.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (normalized_q.size() == 0) begin
        flag_mismatch("result arrived with nothing expected");
      end else begin
        compare_result(out_item_o, normalized_q.pop_front());
      end
      results_seen++;
    end
  end

  // Receiver: a stall pattern of its own, plus one long hold on request.
  initial begin : receiver
    rx_mode_e    rx_mode;
    int unsigned rx_tick;
    int unsigned hold_left;
    rx_mode     = RX_FREE;
    rx_tick     = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request != 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      rx_tick++;
      if (rx_tick % 150 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready_i <= 1'b1;
          RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          RX_BURSTY: out_ready_i <= (rx_tick % 10) >= 7;
          default:   out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    lsn_in_t     item;
    lvl_style_e  style;
    logic [15:0] base;
    int unsigned pick;
    int unsigned batch_len;
    int unsigned batch_idx;
    int unsigned random_sent;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    batch_idx   = 0;
    random_sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, a one-step span, flat batches, a full store.
    foreach (directed_rows[r]) begin
      for (int i = 0; i < directed_rows[r].reps; i++) begin
        item.level   = directed_rows[r].level;
        item.is_last = directed_rows[r].is_last && (i == directed_rows[r].reps - 1);
        send_item(item, directed_rows[r].pinned && item.is_last, directed_rows[r].want);
      end
    end

    // Random batches, mostly short, some long enough to overflow the store.
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        batch_len = $urandom_range(1, 8);
      end else if (pick < 90) begin
        batch_len = $urandom_range(9, 40);
      end else begin
        batch_len = $urandom_range(CAP - 4, CAP + 6);
      end
      style = lvl_style_e'($urandom_range(0, 4));
      base  = 16'($urandom());
      for (int i = 0; i < batch_len; i++) begin
        case (style)
          LV_ANY:     item.level = 16'($urandom());
          LV_CLUSTER: item.level = base + 16'($urandom_range(0, 15));
          LV_FLAT:    item.level = base;
          LV_EDGE:    item.level = $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 1))
                                                        : 16'($urandom_range(0, 1));
          default:    item.level = base ^ 16'($urandom_range(0, 3) << 14);
        endcase
        item.is_last = (i == batch_len - 1);
        send_item(item, 1'b0, NO_PIN);
      end
      random_sent += batch_len;
      batch_idx++;
      // The block is now emitting; hold the receiver off while the next batch
      // is offered, so the input side backs up.
      if (batch_idx == 3) stall_request = LONG_HOLD;
      // Let everything drain before the next batch goes in.
      if (batch_idx == 8) begin
        in_valid_i <= 1'b0;
        while (normalized_q.size() != 0) @(posedge clk_i);
        repeat (30) @(posedge clk_i);
      end
    end

    in_valid_i <= 1'b0;
    while (normalized_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lsn_pkg.sv
design/lightness_span_normalizer_unit.sv
tb/testbench.sv
